@@ design/farf_pkg.sv @@
// ----------------------------------------------------------------------------
// farf_pkg: shared types and constants for the flagged ALU register file
// Opcode encoding, flag bundle, register write port and default sizes.
// ----------------------------------------------------------------------------
package farf_pkg;

  localparam int DATA_W       = 32;
  localparam int REG_IDX_W    = 3;
  localparam int SHAMT_W      = 5;
  localparam int SIGN_BIT     = 31;
  localparam int NUM_REGS_DEF = 8;

  typedef enum logic [2:0] {
    CMD_MOV  = 3'd0,
    CMD_ADDS = 3'd1,
    CMD_SUBS = 3'd2,
    CMD_ANDS = 3'd3,
    CMD_ORR  = 3'd4,
    CMD_EOR  = 3'd5,
    CMD_LSRS = 3'd6,
    CMD_LSLS = 3'd7
  } cmd_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  // register file write request from the execute stage
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } rf_wr_t;

endpackage

@@ design/farf_regfile.sv @@
// ----------------------------------------------------------------------------
// farf_regfile: register file with registered reads and write bypass
// Two read ports sampled at issue, one write port from execute. Entries
// never written since reset read as zero; out-of-range indexes read zero.
// ----------------------------------------------------------------------------
module farf_regfile #(
  parameter int NUM_REGS = farf_pkg::NUM_REGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [farf_pkg::REG_IDX_W-1:0] rd_a_idx,
  input  logic [farf_pkg::REG_IDX_W-1:0] rd_b_idx,
  input  farf_pkg::rf_wr_t               wr,
  output logic [farf_pkg::DATA_W-1:0]    rd_a_r,
  output logic [farf_pkg::DATA_W-1:0]    rd_b_r
);
  import farf_pkg::*;

  localparam int AW = $clog2(NUM_REGS);

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;

  logic          a_ok, b_ok, wr_ok, a_hit, b_hit;
  logic [AW-1:0] a_addr, b_addr, wr_addr;

  assign a_ok    = 32'(rd_a_idx) < NUM_REGS;
  assign b_ok    = 32'(rd_b_idx) < NUM_REGS;
  assign wr_ok   = wr.en && (32'(wr.idx) < NUM_REGS);
  assign a_addr  = AW'(rd_a_idx);
  assign b_addr  = AW'(rd_b_idx);
  assign wr_addr = AW'(wr.idx);
  // write landing on the same edge as the read
  assign a_hit   = wr_ok && (wr.idx == rd_a_idx);
  assign b_hit   = wr_ok && (wr.idx == rd_b_idx);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      priority if (!a_ok) begin
        rd_a_r <= '0;
      end else if (a_hit) begin
        rd_a_r <= wr.data;
      end else if (vld_r[a_addr]) begin
        rd_a_r <= mem[a_addr];
      end else begin
        rd_a_r <= '0;
      end
      priority if (!b_ok) begin
        rd_b_r <= '0;
      end else if (b_hit) begin
        rd_b_r <= wr.data;
      end else if (vld_r[b_addr]) begin
        rd_b_r <= mem[b_addr];
      end else begin
        rd_b_r <= '0;
      end
    end
  end

endmodule

@@ design/farf_alu.sv @@
// ----------------------------------------------------------------------------
// farf_alu: data path of the execute stage
// Computes the result value and the updated NZCV flags for one opcode.
// ----------------------------------------------------------------------------
module farf_alu (
  input  farf_pkg::cmd_t                cmd,
  input  logic [farf_pkg::DATA_W-1:0]   op_a,
  input  logic [farf_pkg::DATA_W-1:0]   op_b,
  input  logic [farf_pkg::DATA_W-1:0]   imm,
  input  logic [farf_pkg::SHAMT_W-1:0]  shamt,
  input  farf_pkg::flags_t              flags_cur,
  output logic [farf_pkg::DATA_W-1:0]   result,
  output farf_pkg::flags_t              flags_nxt
);
  import farf_pkg::*;

  logic [DATA_W:0]    sum_w, diff_w;
  logic [SHAMT_W-1:0] lsr_idx, lsl_idx;
  logic               sh_zero;

  assign sum_w   = {1'b0, op_a} + {1'b0, op_b};
  assign diff_w  = {1'b0, op_a} - {1'b0, op_b};
  assign sh_zero = (shamt == '0);
  assign lsr_idx = shamt - SHAMT_W'(1);   // last bit out of a right shift
  assign lsl_idx = '0 - shamt;            // 32 - shamt, for a left shift

  always_comb begin
    result    = '0;
    flags_nxt = flags_cur;
    unique case (cmd)
      CMD_MOV: begin
        result = imm;
      end
      CMD_ADDS: begin
        result      = sum_w[DATA_W-1:0];
        flags_nxt.c = sum_w[DATA_W];
        flags_nxt.v = ~(op_a[SIGN_BIT] ^ op_b[SIGN_BIT]) &
                      (op_a[SIGN_BIT] ^ result[SIGN_BIT]);
      end
      CMD_SUBS: begin
        result      = diff_w[DATA_W-1:0];
        flags_nxt.c = ~diff_w[DATA_W];    // no borrow
        flags_nxt.v = (op_a[SIGN_BIT] ^ op_b[SIGN_BIT]) &
                      (op_a[SIGN_BIT] ^ result[SIGN_BIT]);
      end
      CMD_ANDS: result = op_a & op_b;
      CMD_ORR:  result = op_a | op_b;
      CMD_EOR:  result = op_a ^ op_b;
      CMD_LSRS: begin
        result = op_a >> shamt;
        if (!sh_zero) begin
          flags_nxt.c = op_a[lsr_idx];
        end
      end
      CMD_LSLS: begin
        result = op_a << shamt;
        if (!sh_zero) begin
          flags_nxt.c = op_a[lsl_idx];
        end
      end
    endcase
    if (cmd != CMD_MOV) begin
      flags_nxt.n = result[SIGN_BIT];
      flags_nxt.z = (result == '0);
    end
  end

endmodule

@@ design/flagged_alu_register_file.sv @@
// ----------------------------------------------------------------------------
// flagged_alu_register_file: ARM-style ALU on a register file with NZCV flags
// Executes MOV, ADDS, SUBS, ANDS, ORR, EOR, LSRS and LSLS, one request per
// item, and returns the value written and the flags after the instruction.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | in_cmd, in_dest, in_src_a, in_src_b,
//           |                      | in_imm, in_shift_amount
//   out     | out_valid / out_ready| out_value, out_flag_n/z/c/v
//
// One request per cycle sustained while the output is not stalled; a request
// passes the operand read register, then execute into the output register.
// Register file and flags are updated when a request leaves execute, so the
// next request reads them directly; a same-edge write is bypassed on read.
// Synchronous active-low reset clears the flags, the register valid bits and
// all handshake state. A stalled output holds execute; in_ready drops only
// when both the execute stage and the output register are occupied.
//
module flagged_alu_register_file #(
  parameter int NUM_REGS = farf_pkg::NUM_REGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_cmd,
  input  logic [farf_pkg::REG_IDX_W-1:0] in_dest,
  input  logic [farf_pkg::REG_IDX_W-1:0] in_src_a,
  input  logic [farf_pkg::REG_IDX_W-1:0] in_src_b,
  input  logic [farf_pkg::DATA_W-1:0]    in_imm,
  input  logic [farf_pkg::SHAMT_W-1:0]   in_shift_amount,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [farf_pkg::DATA_W-1:0]    out_value,
  output logic                           out_flag_n,
  output logic                           out_flag_z,
  output logic                           out_flag_c,
  output logic                           out_flag_v
);
  import farf_pkg::*;

  // execute stage request registers
  logic                 ex_valid_r;
  cmd_t                 ex_cmd_r;
  logic [REG_IDX_W-1:0] ex_dest_r;
  logic [DATA_W-1:0]    ex_imm_r;
  logic [SHAMT_W-1:0]   ex_shamt_r;
  logic [DATA_W-1:0]    ex_a_r, ex_b_r;

  // architectural flags
  flags_t flags_r, flags_nxt;

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  flags_t            out_flags_r;

  logic              in_fire, ex_fire;
  logic [DATA_W-1:0] alu_result;
  rf_wr_t            rf_wr;

  // execute drains when the output register is free or being emptied
  assign ex_fire  = ex_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ex_valid_r || ex_fire;
  assign in_fire  = in_valid && in_ready;

  assign rf_wr.en   = ex_fire;
  assign rf_wr.idx  = ex_dest_r;
  assign rf_wr.data = alu_result;

  farf_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_a_idx (in_src_a),
    .rd_b_idx (in_src_b),
    .wr       (rf_wr),
    .rd_a_r   (ex_a_r),
    .rd_b_r   (ex_b_r)
  );

  farf_alu u_alu (
    .cmd       (ex_cmd_r),
    .op_a      (ex_a_r),
    .op_b      (ex_b_r),
    .imm       (ex_imm_r),
    .shamt     (ex_shamt_r),
    .flags_cur (flags_r),
    .result    (alu_result),
    .flags_nxt (flags_nxt)
  );

  // issue: capture the request; operands come from the register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else if (in_fire) begin
      ex_valid_r <= 1'b1;
    end else if (ex_fire) begin
      ex_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_cmd_r   <= cmd_t'(in_cmd);
      ex_dest_r  <= in_dest;
      ex_imm_r   <= in_imm;
      ex_shamt_r <= in_shift_amount;
    end
  end

  // execute: commit flags and load the output register together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (ex_fire) begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ex_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_value_r <= alu_result;
      out_flags_r <= flags_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_flag_n = out_flags_r.n;
  assign out_flag_z = out_flags_r.z;
  assign out_flag_c = out_flags_r.c;
  assign out_flag_v = out_flags_r.v;

`ifndef NO_ASSERTIONS
  // the flags shown on a pending result are the committed flags
  a_out_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_flags_r == flags_r)
    else $error("output flags differ from committed flags");

  // MOV never touches the flags
  a_mov_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire && ex_cmd_r == CMD_MOV |=> flags_r == $past(flags_r))
    else $error("MOV changed the flags");

  // Z tracks the result for every flag-setting opcode
  a_z_tracks_value: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire && ex_cmd_r != CMD_MOV |=> out_flag_z == (out_value == '0))
    else $error("Z flag does not match result");

  // no request enters while execute is stuck behind a full output
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ex_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("request accepted while execute stalled");

  // a request leaving execute always shows up at the output
  a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire |=> out_valid_r)
    else $error("executed request lost");
`endif

endmodule
